// File: design/set_assoc_branch_target_buffer_defines.svh
// Assertion macros shared by the branch target buffer RTL.
// Each use expects clk and arst_n to be visible in the enclosing module.
`ifndef SET_ASSOC_BRANCH_TARGET_BUFFER_DEFINES_SVH
`define SET_ASSOC_BRANCH_TARGET_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define SBTB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sbtb assertion failed");
// When the condition holds, the consequence must hold in the next cycle.
`define SBTB_ASSERT_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("sbtb assertion failed");
`else
`define SBTB_ASSERT(lbl, prop)
`define SBTB_ASSERT_NEXT(lbl, cond, nxt)
`endif

`endif

// File: design/sbtb_pkg.sv
// Shared types and geometry constants of the branch target buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sbtb_pkg;

	localparam int NUM_SETS  = 128;
	localparam int NUM_WAYS  = 4;
	localparam int ADDR_BITS = 48;

	// Widths fixed by the stream fields.
	localparam int FIELD_ADDR_W = 48;
	localparam int FIELD_LEN_W  = 4;
	localparam int S_TDATA_W    = 104;
	localparam int M_TDATA_W    = 56;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int TAG_W = ADDR_BITS - SET_W;
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int AGE_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);

	// One set row as it sits in the RAM.
	typedef struct packed {
		logic [NUM_WAYS-1:0]                valid;
		logic [NUM_WAYS-1:0][TAG_W-1:0]     tag;
		logic [NUM_WAYS-1:0][AGE_W-1:0]     age;
		logic [NUM_WAYS-1:0][ADDR_BITS-1:0] target;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic update;
	} cmd_t;

endpackage

`default_nettype wire

// File: design/sbtb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; depends on nothing.
`default_nettype none

module sbtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire  logic                         clk,
	input  wire  logic                         we,
	input  wire  logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire  logic [WIDTH-1:0]             wdata,
	input  wire  logic                         re,
	input  wire  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic       [WIDTH-1:0]             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/sbtb_ctrl.sv
// Controller of the branch target buffer: request handshake and update sequencing.
// Depends on sbtb_pkg and the assertion macros header.
`default_nettype none
`include "set_assoc_branch_target_buffer_defines.svh"

module sbtb_ctrl import sbtb_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire  logic m_tready,
	output cmd_t       cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_UPD  = 1'b1;

	logic state_q;
	logic out_valid_q;

	// A request is taken only while idle and the result slot is free or draining.
	assign s_tready   = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign cmd.accept = s_tvalid && s_tready;
	assign cmd.update = (state_q == S_UPD);
	assign m_tvalid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SBTB_ASSERT(a_upd_slot_free, !(cmd.update && out_valid_q))
	`SBTB_ASSERT(a_result_from_update, $rose(out_valid_q) |-> $past(state_q == S_UPD))
	`SBTB_ASSERT_NEXT(a_single_update, state_q == S_UPD, state_q == S_IDLE)

endmodule

`default_nettype wire

// File: design/sbtb_dp.sv
// Datapath of the branch target buffer: request registers, set RAM, lookup,
// LRU update and result register. Depends on sbtb_pkg and sbtb_ram.
`default_nettype none

module sbtb_dp import sbtb_pkg::*; (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  cmd_t                    cmd,
	input  wire  logic [FIELD_ADDR_W-1:0] branch_address,
	input  wire  logic [FIELD_LEN_W-1:0]  instr_length,
	input  wire  logic [FIELD_ADDR_W-1:0] actual_target,
	input  wire  logic                    was_taken,
	output logic                          hit,
	output logic       [FIELD_ADDR_W-1:0] predicted_target,
	output logic                          mispredicted
);

	logic [ADDR_BITS-1:0] addr_ext;
	logic [SET_W-1:0]     set_q;
	logic [TAG_W-1:0]     tag_q;
	logic [ADDR_BITS-1:0] fall_q;
	logic [ADDR_BITS-1:0] actual_q;
	logic                 taken_q;
	logic [NUM_SETS-1:0]  row_written_q;
	logic [ROW_W-1:0]     ram_rdata;

	row_t                 row;
	row_t                 new_row;
	logic                 found;
	logic [WAY_W-1:0]     way;
	logic [ADDR_BITS-1:0] pred;
	logic                 miss;
	logic [WAY_W-1:0]     victim;
	logic                 victim_free;

	logic                 hit_q;
	logic [ADDR_BITS-1:0] pred_q;
	logic                 miss_q;

	assign addr_ext = ADDR_BITS'(branch_address);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q    <= addr_ext[SET_W-1:0];
			tag_q    <= addr_ext[ADDR_BITS-1:SET_W];
			fall_q   <= addr_ext + ADDR_BITS'(instr_length);
			actual_q <= ADDR_BITS'(actual_target);
			taken_q  <= was_taken;
		end
		if (cmd.update) begin
			hit_q  <= found;
			pred_q <= pred;
			miss_q <= miss;
		end
	end

	// A row that was never written reads as the all-zero reset row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_written_q <= '0;
		end else if (cmd.update) begin
			row_written_q[set_q] <= 1'b1;
		end
	end

	sbtb_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (set_q),
		.wdata (new_row),
		.re    (cmd.accept),
		.raddr (addr_ext[SET_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic [AGE_W-1:0] ref_age;
		ref_age = '0;
		row = row_written_q[set_q] ? row_t'(ram_rdata) : row_t'('0);

		found = 1'b0;
		way   = '0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (!found && row.valid[i] && (row.tag[i] == tag_q)) begin
				found = 1'b1;
				way   = WAY_W'(i);
			end
		end
		pred = found ? row.target[way] : fall_q;
		miss = taken_q ? (pred != actual_q) : (pred != fall_q);

		// First free way, otherwise the first way of greatest age.
		victim      = '0;
		victim_free = 1'b0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (!victim_free) begin
				if (!row.valid[i]) begin
					victim      = WAY_W'(i);
					victim_free = 1'b1;
				end else if (row.age[i] > row.age[victim]) begin
					victim = WAY_W'(i);
				end
			end
		end

		new_row = row;
		if (taken_q && miss && found) begin
			new_row.target[way] = actual_q;
		end
		if (taken_q && miss && !found) begin
			ref_age = row.age[victim];
			for (int i = 0; i < NUM_WAYS; i++) begin
				if (victim_free) begin
					if ((WAY_W'(i) != victim) && row.valid[i] && (row.age[i] < AGE_MAX)) begin
						new_row.age[i] = row.age[i] + AGE_W'(1);
					end
				end else if (row.valid[i] && (row.age[i] < ref_age)) begin
					new_row.age[i] = row.age[i] + AGE_W'(1);
				end
			end
			new_row.age[victim]    = '0;
			new_row.valid[victim]  = 1'b1;
			new_row.tag[victim]    = tag_q;
			new_row.target[victim] = actual_q;
		end
		if (!taken_q && found) begin
			new_row.valid[way] = 1'b0;
		end
		if (found) begin
			ref_age = row.age[way];
			for (int i = 0; i < NUM_WAYS; i++) begin
				if (new_row.valid[i] && (row.age[i] < ref_age)) begin
					new_row.age[i] = row.age[i] + AGE_W'(1);
				end
			end
			new_row.age[way] = '0;
		end
	end

	assign hit              = hit_q;
	assign predicted_target = FIELD_ADDR_W'(pred_q);
	assign mispredicted     = miss_q;

endmodule

`default_nettype wire

// File: design/set_assoc_branch_target_buffer.sv
// Set-associative branch target buffer with LRU ages. Each request is one resolved
// branch; the block answers with one result (hit, predicted target, mispredicted)
// and updates the set the branch maps to. The set row is read from the single RAM in
// the cycle the request is accepted and written back with the new ages, tags and
// targets in the next one; no new request is taken while that write-back is pending.
// The result sits in an output register; the next request is taken only once that
// register is empty or is being read in the same cycle, so a stalled result stream
// holds off the input. After reset no clearing pass is needed: a flag per set marks
// rows written since reset, and a row not yet written reads as empty, so requests
// are taken from the first cycle. Depends on sbtb_pkg, sbtb_ctrl and sbtb_dp.
`default_nettype none

module set_assoc_branch_target_buffer import sbtb_pkg::*; (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	// Request stream.
	input  wire  logic                 s_tvalid,
	output logic                       s_tready,
	// [47:0] branch_address, [51:48] instr_length, [99:52] actual_target,
	// [100] was_taken, [103:101] zero.
	input  wire  logic [S_TDATA_W-1:0] s_tdata,
	// Result stream.
	output logic                       m_tvalid,
	input  wire  logic                 m_tready,
	// [0] hit, [48:1] predicted_target, [49] mispredicted, [55:50] zero.
	output logic       [M_TDATA_W-1:0] m_tdata
);

	cmd_t                    cmd;
	logic                    hit;
	logic [FIELD_ADDR_W-1:0] predicted_target;
	logic                    mispredicted;

	// The controller owns the handshakes and tells the datapath when to
	// capture a request and when to commit the set update and result.
	sbtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sbtb_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.branch_address   (s_tdata[47:0]),
		.instr_length     (s_tdata[51:48]),
		.actual_target    (s_tdata[99:52]),
		.was_taken        (s_tdata[100]),
		.hit              (hit),
		.predicted_target (predicted_target),
		.mispredicted     (mispredicted)
	);

	assign m_tdata = {6'b0, mispredicted, predicted_target, hit};

endmodule

`default_nettype wire
